[rtl/core/sts_pkg.sv]
package sts_pkg;

  localparam int unsigned Trackers    = 4;
  localparam int unsigned MaxLen      = 64;
  localparam int unsigned Stride      = 16;
  localparam int unsigned StrideW     = $clog2(Stride);
  localparam int unsigned AddrW       = 20;
  localparam int unsigned SigBytes    = 8;
  localparam int unsigned RevOffset   = 15;
  localparam int unsigned BaseBytes   = 20;
  localparam int unsigned HdrBytes    = 24;
  localparam int unsigned ExtRevision = 2;
  localparam int unsigned PreW        = $clog2(HdrBytes);
  localparam int unsigned InDataW     = 32;
  localparam int unsigned OutDataW    = 24;

  // per-tracker control for one accepted byte
  typedef struct packed {
    logic en;
    logic rstart;
    logic rend;
    logic open;
  } sts_ctl_t;

  // tracker status after feeding the current byte
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [AddrW-1:0] start;
  } sts_trk_t;

  // "RSD PTR "
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h52;
      3'd1:    c = 8'h53;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h20;
      3'd4:    c = 8'h50;
      3'd5:    c = 8'h54;
      3'd6:    c = 8'h52;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/signed_table_scanner.sv]
// Channel   Dir  Payload (low bit up)                          Marks
// s_axis    in   tdata: byte_value[7:0], byte_addr[27:8], 0    tuser region_start, tlast region_end
// m_axis    out  tdata: found_addr[19:0], 0                    tuser found
//
// One byte is taken every cycle while s_axis_tready_o is high; all trackers update in parallel on it.
// A region_end byte's result is registered in the output register, or in skid if that is full.
// Reset clears trackers, best result and output/skid valid bits.
// A pending result does not block input; a second result waiting behind it
// sits in a skid register and only then is s_axis_tready_o dropped.
module signed_table_scanner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [sts_pkg::InDataW-1:0]  s_axis_tdata_i,   // byte_value, byte_addr
  input  logic                         s_axis_tuser_i,   // region_start
  input  logic                         s_axis_tlast_i,   // region_end
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [sts_pkg::OutDataW-1:0] m_axis_tdata_o,   // found_addr
  output logic                         m_axis_tuser_o    // found
);
  import sts_pkg::*;

  logic             acc;
  logic [7:0]       byte_val;
  logic [AddrW-1:0] byte_addr;
  logic             rstart;
  logic             rend;

  sts_ctl_t         ctl [Trackers];
  sts_trk_t         trk [Trackers];
  logic [Trackers-1:0] open_vec;

  logic             best_v_q;
  logic [AddrW-1:0] best_a_q;
  logic             best_v;
  logic [AddrW-1:0] best_a;
  logic             open_ok;
  logic             taken;

  logic             out_v_q, skid_v_q;
  logic             out_f_q, skid_f_q;
  logic [AddrW-1:0] out_a_q, skid_a_q;
  logic             push, pop;
  logic             res_f;
  logic [AddrW-1:0] res_a;

  assign s_axis_tready_o = ~skid_v_q;
  assign acc       = s_axis_tvalid_i & s_axis_tready_o;
  assign byte_val  = s_axis_tdata_i[7:0];
  assign byte_addr = s_axis_tdata_i[8 +: AddrW];
  assign rstart    = s_axis_tuser_i;
  assign rend      = s_axis_tlast_i;

  for (genvar g = 0; g < Trackers; g++) begin : g_trk
    assign ctl[g] = '{en: acc, rstart: rstart, rend: rend, open: open_vec[g]};
    sts_tracker u_trk (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .byte_i (byte_val),
      .addr_i (byte_addr),
      .stat_o (trk[g])
    );
  end

  // lowest hit so far; with none, open a candidate in the first free tracker on an aligned byte
  always_comb begin
    best_v = best_v_q & ~rstart;
    best_a = rstart ? '0 : best_a_q;
    for (int t = 0; t < Trackers; t++) begin
      if (trk[t].hit && (!best_v || trk[t].start < best_a)) begin
        best_v = 1'b1;
        best_a = trk[t].start;
      end
    end
    open_ok = acc && byte_addr[StrideW-1:0] == '0 && !best_v;
    taken   = 1'b0;
    for (int t = 0; t < Trackers; t++) begin
      open_vec[t] = open_ok & ~taken & ~trk[t].active;
      taken       = taken | ~trk[t].active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_v_q <= 1'b0;
      best_a_q <= '0;
    end else if (acc) begin
      if (rend) begin
        best_v_q <= 1'b0;
        best_a_q <= '0;
      end else begin
        best_v_q <= best_v;
        best_a_q <= best_a;
      end
    end
  end

  assign push  = acc & rend;
  assign pop   = out_v_q & m_axis_tready_i;
  assign res_f = best_v;
  assign res_a = best_v ? best_a : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      if (!out_v_q) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        out_f_q <= skid_f_q;
        out_a_q <= skid_a_q;
      end else begin
        out_f_q <= res_f;
        out_a_q <= res_a;
      end
    end else if (push) begin
      if (!out_v_q) begin
        out_f_q <= res_f;
        out_a_q <= res_a;
      end else begin
        skid_f_q <= res_f;
        skid_a_q <= res_a;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_f_q;
  assign m_axis_tdata_o  = OutDataW'(out_a_q);

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while output register is empty");

  a_open_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(open_vec))
    else $error("more than one tracker opened on one byte");

  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && rend) |=> (!best_v_q && best_a_q == '0))
    else $error("best result not cleared after region end");

  a_no_open_when_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_v_q && !rstart) |-> (open_vec == '0))
    else $error("candidate opened after a valid one was recorded");

  a_addr_zero_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("nonzero address reported without a find");
`endif

endmodule

[rtl/core/sts_tracker.sv]
module sts_tracker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sts_pkg::sts_ctl_t         ctl_i,
  input  logic [7:0]                byte_i,
  input  logic [sts_pkg::AddrW-1:0] addr_i,
  output sts_pkg::sts_trk_t         stat_o
);
  import sts_pkg::*;

  logic             act_q, act_d;
  logic [AddrW-1:0] start_q;
  logic [7:0]       off_q;
  logic [7:0]       sum_q;
  logic             rev_ext_q;
  logic [23:0]      len_q;
  logic [7:0]       pre_q [HdrBytes];

  logic             act_eff;
  logic [7:0]       sum_new;
  logic [31:0]      len_full;
  logic [PreW-1:0]  pre_idx;
  logic [7:0]       pre_val;
  logic [8:0]       off_nxt;
  logic             fail;
  logic             hit;
  logic             act_feed;

  assign act_eff  = act_q & ~ctl_i.rstart;
  assign sum_new  = sum_q + byte_i;
  assign len_full = {byte_i, len_q};
  assign pre_idx  = len_full[PreW-1:0] - PreW'(1);
  assign off_nxt  = {1'b0, off_q} + 9'd1;

  always_comb begin
    fail    = 1'b0;
    hit     = 1'b0;
    pre_val = sum_new;
    if (pre_idx != PreW'(HdrBytes - 1) && len_full <= 32'(HdrBytes) && len_full != 32'd0) begin
      pre_val = pre_q[pre_idx];
    end
    if (off_q < 8'(SigBytes)) begin
      fail = (byte_i != sig_byte(off_q[2:0]));
    end else if (off_q == 8'(BaseBytes - 1)) begin
      if (sum_new != 8'd0) begin
        fail = 1'b1;
      end else begin
        hit = ~rev_ext_q;
      end
    end else if (off_q == 8'(HdrBytes - 1)) begin
      if (len_full > 32'(MaxLen)) begin
        fail = 1'b1;
      end else if (len_full == 32'd0) begin
        hit = 1'b1;
      end else if (len_full <= 32'(HdrBytes)) begin
        hit  = (pre_val == 8'd0);
        fail = (pre_val != 8'd0);
      end
    end else if (off_q >= 8'(HdrBytes) && off_nxt == len_q[8:0]) begin
      hit  = (sum_new == 8'd0);
      fail = (sum_new != 8'd0);
    end
    hit      = hit & act_eff;
    act_feed = act_eff & ~fail & ~hit;
  end

  always_comb begin
    act_d = act_q;
    if (ctl_i.en) begin
      if (ctl_i.rend) begin
        act_d = 1'b0;
      end else if (ctl_i.open) begin
        act_d = (byte_i == sig_byte(3'd0));
      end else begin
        act_d = act_feed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  // candidate payload, written before it is read
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.open) begin
        start_q    <= addr_i;
        off_q      <= 8'd1;
        sum_q      <= byte_i;
        pre_q[0]   <= byte_i;
      end else if (act_eff) begin
        off_q <= off_nxt[7:0];
        sum_q <= sum_new;
        if (off_q < 8'(HdrBytes)) begin
          pre_q[off_q[PreW-1:0]] <= sum_new;
        end
        if (off_q == 8'(RevOffset)) begin
          rev_ext_q <= (byte_i >= 8'(ExtRevision));
        end
        case (off_q)
          8'(BaseBytes):     len_q[7:0]   <= byte_i;
          8'(BaseBytes + 1): len_q[15:8]  <= byte_i;
          8'(BaseBytes + 2): len_q[23:16] <= byte_i;
          default: ;
        endcase
      end
    end
  end

  assign stat_o.active = act_feed;
  assign stat_o.hit    = hit;
  assign stat_o.start  = start_q;

endmodule
